[sv/csa_pkg.sv]
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants for the contiguous segment allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int unsigned MEM_BYTES    = 1048576;
    localparam int unsigned HOLE_ENTRIES = 32;
    localparam int unsigned SEG_ENTRIES  = 32;
    localparam int unsigned ADDR_W       = 21;
    localparam int unsigned CNT_W        = 6;
    localparam int unsigned IDX_W        = 5;
    localparam int unsigned ID_W         = 16;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_COMPACT = 2'd2;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_NO_ID    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HSCAN,      // hole fit search, one entry a cycle
        S_HCARVE,     // update chosen hole
        S_HDROP,      // shift holes down over emptied entry
        S_SPOS,       // find segment insert position
        S_SSHIFT,     // shift segments up, write new entry
        S_RSCAN,      // search segment by owner
        S_RDROP,      // shift segments down
        S_HPOS,       // find hole insert position
        S_HSHIFT,     // shift holes up, write new entry
        S_CPACK,      // compaction walk
        S_DONE
    } state_t;

endpackage

[sv/contiguous_segment_allocator_core.sv]
// ----------------------------------------------------------------------------
// contiguous_segment_allocator_core
// First/best/worst fit allocator over ordered hole and segment tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (in_valid/in_stall): one request transaction carrying
//   req_type, req_bytes, fit_strategy and proc_id. in_stall is high while a
//   request is in progress or its result has not been taken.
//   Output channel (out_valid/out_stall): one result transaction per request
//   with status, seg_begin, seg_end, holes_in_use and segments_in_use.
//   Operation: one request at a time, one table entry per cycle. Allocate:
//   hole scan, carve of the chosen hole, hole drop if it was emptied, then
//   segment insert (position search and shift) and the result. Release:
//   owner scan, segment drop, then hole insert (position search and shift).
//   Compact: one walk over the segments. A full table or an unknown request
//   goes straight to the result.
//   The next request is taken in the cycle after the result transaction.
//   Reset: hole table holds the single hole [0, MEM_BYTES), no segments.
//   Segment entries are undefined until written and need no clearing.
//   While out_stall is high the result holds and no new request is taken.
// ----------------------------------------------------------------------------
module contiguous_segment_allocator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [20:0] req_bytes,
    input  logic [1:0]  fit_strategy,
    input  logic [15:0] proc_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [20:0] seg_begin,
    output logic [20:0] seg_end,
    output logic [5:0]  holes_in_use,
    output logic [5:0]  segments_in_use
);

    // Tables (hole entry 0 reset value handled by registers; others unread
    // above hole_count so need no reset).
    csa_pkg::addr_t hs_mem [csa_pkg::HOLE_ENTRIES];
    csa_pkg::addr_t hl_mem [csa_pkg::HOLE_ENTRIES];
    logic [csa_pkg::ID_W-1:0] so_mem [csa_pkg::SEG_ENTRIES];
    csa_pkg::addr_t ss_mem [csa_pkg::SEG_ENTRIES];
    csa_pkg::addr_t sl_mem [csa_pkg::SEG_ENTRIES];

    csa_pkg::state_t state_reg, state_next;
    csa_pkg::cnt_t   hcnt_reg, scnt_reg;
    csa_pkg::cnt_t   i_reg;              // walk index
    csa_pkg::cnt_t   pick_reg;           // chosen hole / found segment
    logic            found_reg;          // hole found; in drop: hole emptied
    csa_pkg::addr_t  best_reg;
    csa_pkg::addr_t  top_reg;            // compaction top
    csa_pkg::addr_t  b_reg, e_reg;
    logic [1:0]      st_reg;
    logic            init_reg;           // hole 0 still at its reset value

    // latched request
    logic [1:0]      strat_reg;
    csa_pkg::addr_t  bytes_reg;
    logic [csa_pkg::ID_W-1:0] id_reg;

    logic [1:0]      st_out_reg;
    csa_pkg::addr_t  b_out_reg, e_out_reg;

    csa_pkg::idx_t   ix, ixp;
    assign ix  = i_reg[csa_pkg::IDX_W-1:0];
    assign ixp = ix + csa_pkg::idx_t'(1);

    // hole entry read with reset override for entry 0
    csa_pkg::addr_t  h_s, h_l, h_sz, h_s1, h_l1;
    always_comb
    begin
        h_s  = hs_mem[ix];
        h_l  = hl_mem[ix];
        h_s1 = hs_mem[ixp];
        h_l1 = hl_mem[ixp];
        if (init_reg && ix == '0)
        begin
            h_s = '0;
            h_l = csa_pkg::addr_t'(csa_pkg::MEM_BYTES);
        end
        h_sz = (h_l >= h_s) ? h_l - h_s : '0;
    end

    logic fits, take;
    always_comb
    begin
        fits = (h_sz >= bytes_reg);
        take = fits && (!found_reg ||
               (strat_reg == csa_pkg::FIT_BEST  && h_sz <= best_reg) ||
               (strat_reg == csa_pkg::FIT_WORST && h_sz >= best_reg));
    end

    csa_pkg::addr_t carve_end;
    assign carve_end = h_s + bytes_reg;

    assign in_stall  = (state_reg != csa_pkg::S_IDLE);
    assign out_valid = (state_reg == csa_pkg::S_DONE);
    assign status          = st_out_reg;
    assign seg_begin       = b_out_reg;
    assign seg_end         = e_out_reg;
    assign holes_in_use    = hcnt_reg;
    assign segments_in_use = scnt_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csa_pkg::S_IDLE:
                if (in_valid)
                begin
                    case (req_type)
                        csa_pkg::REQ_ALLOC:
                            state_next = (scnt_reg == csa_pkg::cnt_t'(csa_pkg::SEG_ENTRIES))
                                ? csa_pkg::S_DONE : csa_pkg::S_HSCAN;
                        csa_pkg::REQ_RELEASE: state_next = csa_pkg::S_RSCAN;
                        csa_pkg::REQ_COMPACT: state_next = csa_pkg::S_CPACK;
                        default:              state_next = csa_pkg::S_DONE;
                    endcase
                end
            csa_pkg::S_HSCAN:
                if (i_reg >= hcnt_reg)
                    state_next = found_reg ? csa_pkg::S_HCARVE : csa_pkg::S_DONE;
                else if (take && strat_reg == csa_pkg::FIT_FIRST)
                    state_next = csa_pkg::S_HCARVE;
            csa_pkg::S_HCARVE:
                state_next = csa_pkg::S_HDROP;
            csa_pkg::S_HDROP:
                if (!found_reg || i_reg + 1'b1 >= hcnt_reg)
                    state_next = csa_pkg::S_SPOS;
            csa_pkg::S_SPOS:
                if (i_reg >= scnt_reg || ss_mem[ix] > b_reg)
                    state_next = csa_pkg::S_SSHIFT;
            csa_pkg::S_SSHIFT:
                if (i_reg == pick_reg)
                    state_next = csa_pkg::S_DONE;
            csa_pkg::S_RSCAN:
                if (i_reg >= scnt_reg)
                    state_next = csa_pkg::S_DONE;
                else if (so_mem[ix] == id_reg)
                    state_next = (hcnt_reg == csa_pkg::cnt_t'(csa_pkg::HOLE_ENTRIES))
                        ? csa_pkg::S_DONE : csa_pkg::S_RDROP;
            csa_pkg::S_RDROP:
                if (i_reg + 1'b1 >= scnt_reg)
                    state_next = csa_pkg::S_HPOS;
            csa_pkg::S_HPOS:
                if (i_reg >= hcnt_reg || h_s > b_reg)
                    state_next = csa_pkg::S_HSHIFT;
            csa_pkg::S_HSHIFT:
                if (i_reg == pick_reg)
                    state_next = csa_pkg::S_DONE;
            csa_pkg::S_CPACK:
                if (i_reg >= scnt_reg)
                    state_next = csa_pkg::S_DONE;
            csa_pkg::S_DONE:
                if (!out_stall)
                    state_next = csa_pkg::S_IDLE;
            default:
                state_next = csa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csa_pkg::S_IDLE;
            hcnt_reg  <= csa_pkg::cnt_t'(1);
            scnt_reg  <= '0;
            init_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                csa_pkg::S_HDROP:
                    if (found_reg && i_reg + 1'b1 >= hcnt_reg)
                        hcnt_reg <= hcnt_reg - 1'b1;
                csa_pkg::S_SSHIFT:
                    if (i_reg == pick_reg)
                        scnt_reg <= scnt_reg + 1'b1;
                csa_pkg::S_RDROP:
                    if (i_reg + 1'b1 >= scnt_reg)
                        scnt_reg <= scnt_reg - 1'b1;
                csa_pkg::S_HSHIFT:
                    if (i_reg == pick_reg)
                    begin
                        hcnt_reg <= hcnt_reg + 1'b1;
                        init_reg <= 1'b0;
                    end
                csa_pkg::S_HCARVE:
                    init_reg <= 1'b0;
                csa_pkg::S_CPACK:
                    if (i_reg >= scnt_reg)
                    begin
                        hcnt_reg <= csa_pkg::cnt_t'(1);
                        init_reg <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

    // datapath and tables
    always_ff @(posedge clk)
    begin
        case (state_reg)
            csa_pkg::S_IDLE:
                if (in_valid)
                begin
                    strat_reg <= fit_strategy;
                    bytes_reg <= req_bytes;
                    id_reg    <= proc_id;
                    found_reg <= 1'b0;
                    best_reg  <= '0;
                    top_reg   <= '0;
                    b_reg     <= '0;
                    e_reg     <= '0;
                    st_reg    <= (req_type == csa_pkg::REQ_RELEASE) ? csa_pkg::ST_NO_ID
                               : (req_type == csa_pkg::REQ_ALLOC) ? csa_pkg::ST_NO_FIT
                               : csa_pkg::ST_OK;
                    // a zero size or unknown strategy never fits
                    if (req_type == csa_pkg::REQ_ALLOC &&
                        (req_bytes == '0 || fit_strategy > csa_pkg::FIT_WORST))
                        i_reg <= csa_pkg::cnt_t'(csa_pkg::HOLE_ENTRIES);
                    else
                        i_reg <= '0;
                end
            csa_pkg::S_HSCAN:
                if (i_reg < hcnt_reg)
                begin
                    if (take)
                    begin
                        found_reg <= 1'b1;
                        pick_reg  <= i_reg;
                        best_reg  <= h_sz;
                    end
                    if (!(take && strat_reg == csa_pkg::FIT_FIRST))
                        i_reg <= i_reg + 1'b1;
                end
                else
                    i_reg <= pick_reg;
            csa_pkg::S_HCARVE:
            begin
                // carve from low end of chosen hole (i_reg points at it)
                b_reg  <= h_s;
                e_reg  <= carve_end;
                hs_mem[ix] <= carve_end;
                hl_mem[ix] <= h_l;
                i_reg  <= pick_reg;
                found_reg <= (carve_end == h_l);
                st_reg <= csa_pkg::ST_OK;
            end
            csa_pkg::S_HDROP:
                // emptied hole: shift the entries above it down
                if (found_reg && i_reg + 1'b1 < hcnt_reg)
                begin
                    hs_mem[ix] <= h_s1;
                    hl_mem[ix] <= h_l1;
                    i_reg <= i_reg + 1'b1;
                end
                else
                    i_reg <= '0;
            csa_pkg::S_SPOS:
                if (i_reg >= scnt_reg || ss_mem[ix] > b_reg)
                begin
                    pick_reg <= i_reg;
                    i_reg    <= scnt_reg;
                end
                else
                    i_reg <= i_reg + 1'b1;
            csa_pkg::S_SSHIFT:
            begin
                if (i_reg == pick_reg)
                begin
                    so_mem[ix] <= id_reg;
                    ss_mem[ix] <= b_reg;
                    sl_mem[ix] <= e_reg;
                end
                else
                begin
                    so_mem[ix] <= so_mem[ix - 1'b1];
                    ss_mem[ix] <= ss_mem[ix - 1'b1];
                    sl_mem[ix] <= sl_mem[ix - 1'b1];
                    i_reg <= i_reg - 1'b1;
                end
            end
            csa_pkg::S_RSCAN:
                if (i_reg < scnt_reg)
                begin
                    if (so_mem[ix] == id_reg)
                    begin
                        if (hcnt_reg == csa_pkg::cnt_t'(csa_pkg::HOLE_ENTRIES))
                            st_reg <= csa_pkg::ST_FULL;
                        else
                        begin
                            st_reg <= csa_pkg::ST_OK;
                            b_reg  <= ss_mem[ix];
                            e_reg  <= sl_mem[ix];
                        end
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
            csa_pkg::S_RDROP:
                if (i_reg + 1'b1 < scnt_reg)
                begin
                    so_mem[ix] <= so_mem[ixp];
                    ss_mem[ix] <= ss_mem[ixp];
                    sl_mem[ix] <= sl_mem[ixp];
                    i_reg <= i_reg + 1'b1;
                end
                else
                    i_reg <= '0;
            csa_pkg::S_HPOS:
                if (i_reg >= hcnt_reg || h_s > b_reg)
                begin
                    pick_reg <= i_reg;
                    i_reg    <= hcnt_reg;
                    // materialise reset hole before shifting
                    if (init_reg)
                    begin
                        hs_mem[0] <= '0;
                        hl_mem[0] <= csa_pkg::addr_t'(csa_pkg::MEM_BYTES);
                    end
                end
                else
                    i_reg <= i_reg + 1'b1;
            csa_pkg::S_HSHIFT:
            begin
                if (i_reg == pick_reg)
                begin
                    hs_mem[ix] <= b_reg;
                    hl_mem[ix] <= e_reg;
                end
                else
                begin
                    hs_mem[ix] <= hs_mem[ix - 1'b1];
                    hl_mem[ix] <= hl_mem[ix - 1'b1];
                    i_reg <= i_reg - 1'b1;
                end
            end
            csa_pkg::S_CPACK:
                if (i_reg >= scnt_reg)
                begin
                    hs_mem[0] <= top_reg;
                    hl_mem[0] <= csa_pkg::addr_t'(csa_pkg::MEM_BYTES);
                    e_reg     <= top_reg;
                end
                else
                begin
                    ss_mem[ix] <= top_reg;
                    sl_mem[ix] <= top_reg + (sl_mem[ix] - ss_mem[ix]);
                    top_reg    <= top_reg + (sl_mem[ix] - ss_mem[ix]);
                    i_reg      <= i_reg + 1'b1;
                end
            default: ;
        endcase
        if (state_reg != csa_pkg::S_DONE && state_next == csa_pkg::S_DONE)
        begin
            if (state_reg == csa_pkg::S_IDLE)
            begin
                st_out_reg <= (req_type == csa_pkg::REQ_ALLOC)
                    ? csa_pkg::ST_FULL : csa_pkg::ST_OK;
                b_out_reg  <= '0;
                e_out_reg  <= '0;
            end
            else if (state_reg == csa_pkg::S_HSCAN)
            begin
                st_out_reg <= csa_pkg::ST_NO_FIT;
                b_out_reg  <= '0;
                e_out_reg  <= '0;
            end
            else if (state_reg == csa_pkg::S_RSCAN)
            begin
                st_out_reg <= (i_reg >= scnt_reg) ? csa_pkg::ST_NO_ID : csa_pkg::ST_FULL;
                b_out_reg  <= '0;
                e_out_reg  <= '0;
            end
            else if (state_reg == csa_pkg::S_CPACK)
            begin
                st_out_reg <= csa_pkg::ST_OK;
                b_out_reg  <= '0;
                e_out_reg  <= top_reg;
            end
            else
            begin
                st_out_reg <= st_reg;
                b_out_reg  <= b_reg;
                e_out_reg  <= e_reg;
            end
        end
    end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the contiguous segment allocator core. A directed
// stimulus table (reset state, extremes, error codes, full memory) is
// followed by a table-filling phase and random allocate/release/compact
// traffic. Every result transaction is checked: against the typed-in outcome
// for directed rows that have one, else against an in-bench table model.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import csa_pkg::*;

    localparam int unsigned NO_HOLE     = HOLE_ENTRIES;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_REQS = 1650;
    localparam logic [1:0]  REQ_NONE    = 2'd3;   // unused request code
    localparam logic [1:0]  FIT_BAD     = 2'd3;   // unused strategy code

    typedef struct {
        logic [1:0]  kind;
        logic [20:0] bytes;
        logic [1:0]  fit;
        logic [15:0] owner;
    } request_t;

    typedef struct {
        logic [1:0]  code;
        logic [20:0] lo;
        logic [20:0] hi;
        logic [5:0]  holes;
        logic [5:0]  segs;
    } outcome_t;

    // Directed row: request, whether an outcome is typed in, and that outcome
    typedef struct {
        request_t req;
        bit       typed;
        outcome_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [20:0] req_bytes = '0;
    logic [1:0]  fit_strategy = '0;
    logic [15:0] proc_id = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [20:0] seg_begin;
    logic [20:0] seg_end;
    logic [5:0]  holes_in_use;
    logic [5:0]  segments_in_use;

    contiguous_segment_allocator_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---- table model ------------------------------------------------------
    int unsigned gap_lo [HOLE_ENTRIES];
    int unsigned gap_hi [HOLE_ENTRIES];
    int unsigned gap_n;
    int unsigned blk_owner [SEG_ENTRIES];
    int unsigned blk_lo [SEG_ENTRIES];
    int unsigned blk_hi [SEG_ENTRIES];
    int unsigned blk_n;

    outcome_t    pending_q [$];
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned sent = 0;
    int unsigned cycles = 0;
    int unsigned kind_seen [4];
    int unsigned code_seen [4];
    bit          calm = 1'b0;    // no idling on either side while set

    function automatic int unsigned choose_gap(int unsigned bytes, logic [1:0] fit);
        int unsigned pick;
        int unsigned best;
        int unsigned sz;
        pick = NO_HOLE;
        best = 0;
        for (int unsigned i = 0; i < gap_n; i++)
        begin
            sz = (gap_hi[i] >= gap_lo[i]) ? gap_hi[i] - gap_lo[i] : 0;
            if (sz < bytes)
                continue;
            if (fit == FIT_FIRST)
                return i;
            // ties fall to the later hole
            if (pick == NO_HOLE || (fit == FIT_BEST && sz <= best) ||
                (fit == FIT_WORST && sz >= best))
            begin
                pick = i;
                best = sz;
            end
        end
        return pick;
    endfunction

    function automatic outcome_t serve(request_t r);
        outcome_t    o;
        int unsigned h;
        int unsigned b;
        int unsigned e;
        int unsigned p;
        int unsigned top;
        int unsigned len;
        b = 0;
        e = 0;
        o.code = ST_OK;
        case (r.kind)
            REQ_ALLOC:
            begin
                if (blk_n >= SEG_ENTRIES)
                    o.code = ST_FULL;
                else
                begin
                    h = (r.bytes == 0 || r.fit == FIT_BAD) ? NO_HOLE
                                                          : choose_gap(r.bytes, r.fit);
                    if (h >= NO_HOLE)
                        o.code = ST_NO_FIT;
                    else
                    begin
                        b = gap_lo[h];
                        e = b + r.bytes;
                        gap_lo[h] = e;
                        if (gap_hi[h] == e)
                        begin
                            for (int unsigned i = h; i + 1 < gap_n; i++)
                            begin
                                gap_lo[i] = gap_lo[i+1];
                                gap_hi[i] = gap_hi[i+1];
                            end
                            gap_n--;
                        end
                        p = 0;
                        while (p < blk_n && blk_lo[p] <= b)
                            p++;
                        for (int unsigned i = blk_n; i > p; i--)
                        begin
                            blk_owner[i] = blk_owner[i-1];
                            blk_lo[i] = blk_lo[i-1];
                            blk_hi[i] = blk_hi[i-1];
                        end
                        blk_owner[p] = r.owner;
                        blk_lo[p] = b;
                        blk_hi[p] = e;
                        blk_n++;
                    end
                end
            end
            REQ_RELEASE:
            begin
                p = 0;
                while (p < blk_n && blk_owner[p] != r.owner)
                    p++;
                if (p >= blk_n)
                    o.code = ST_NO_ID;
                else if (gap_n >= HOLE_ENTRIES)
                    o.code = ST_FULL;
                else
                begin
                    b = blk_lo[p];
                    e = blk_hi[p];
                    for (int unsigned i = p; i + 1 < blk_n; i++)
                    begin
                        blk_owner[i] = blk_owner[i+1];
                        blk_lo[i] = blk_lo[i+1];
                        blk_hi[i] = blk_hi[i+1];
                    end
                    blk_n--;
                    p = 0;
                    while (p < gap_n && gap_lo[p] <= b)
                        p++;
                    for (int unsigned i = gap_n; i > p; i--)
                    begin
                        gap_lo[i] = gap_lo[i-1];
                        gap_hi[i] = gap_hi[i-1];
                    end
                    gap_lo[p] = b;
                    gap_hi[p] = e;
                    gap_n++;
                end
            end
            REQ_COMPACT:
            begin
                top = 0;
                for (int unsigned i = 0; i < blk_n; i++)
                begin
                    len = blk_hi[i] - blk_lo[i];
                    blk_lo[i] = top;
                    top += len;
                    blk_hi[i] = top;
                end
                gap_lo[0] = top;
                gap_hi[0] = MEM_BYTES;
                gap_n = 1;
                e = top;
            end
            default: ;
        endcase
        if (o.code != ST_OK)
        begin
            b = 0;
            e = 0;
        end
        o.lo = b[20:0];
        o.hi = e[20:0];
        o.holes = gap_n[5:0];
        o.segs = blk_n[5:0];
        return o;
    endfunction

    // ---- request side -----------------------------------------------------
    // Drives one request transaction from the falling edge, holds it until
    // taken, and files its expected outcome at the accepting edge.
    task automatic issue(request_t r, bit typed = 1'b0, outcome_t want = '{default: '0});
        outcome_t o;
        @(negedge clk);
        if (!calm && $urandom_range(99) < 28)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = r.kind;
        req_bytes = r.bytes;
        fit_strategy = r.fit;
        proc_id = r.owner;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        o = serve(r);
        pending_q.push_back(typed ? want : o);
        kind_seen[r.kind]++;
        sent++;
        // valid drops after the accepting edge
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic request_t random_request();
        request_t r;
        int unsigned k;
        k = $urandom_range(99);
        r.kind = (k < 52) ? REQ_ALLOC : (k < 88) ? REQ_RELEASE :
                 (k < 97) ? REQ_COMPACT : REQ_NONE;
        k = $urandom_range(99);
        if (k < 60)
            r.bytes = 21'($urandom_range(1, 4096));
        else if (k < 85)
            r.bytes = 21'($urandom_range(1, 65536));
        else if (k < 95)
            r.bytes = 21'($urandom_range(0, MEM_BYTES));
        else
            r.bytes = 21'($urandom_range(0, 21'h1FFFFF));
        r.fit = ($urandom_range(99) < 4) ? FIT_BAD : 2'($urandom_range(2));
        r.owner = ($urandom_range(99) < 85) ? 16'($urandom_range(15)) : 16'($urandom);
        return r;
    endfunction

    // ---- result side ------------------------------------------------------
    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        errors++;
    endtask

    always @(negedge clk)
    begin
        if (!calm && $urandom_range(99) < 28)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        outcome_t w;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_q.size());
            $display("FAIL");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
                report("unexpected result status", 32'(status), 32'd0);
            else
            begin
                w = pending_q.pop_front();
                code_seen[status]++;
                if (status != w.code)
                    report("status", 32'(status), 32'(w.code));
                if (seg_begin != w.lo)
                    report("seg_begin", 32'(seg_begin), 32'(w.lo));
                if (seg_end != w.hi)
                    report("seg_end", 32'(seg_end), 32'(w.hi));
                if (holes_in_use != w.holes)
                    report("holes_in_use", 32'(holes_in_use), 32'(w.holes));
                if (segments_in_use != w.segs)
                    report("segments_in_use", 32'(segments_in_use), 32'(w.segs));
            end
            results_seen++;
        end
    end

    // ---- stimulus ---------------------------------------------------------
    row_t plan [24] = '{
        // first request from reset: hole [0, MEM) split at the bottom
        '{'{REQ_ALLOC, 21'd1024, FIT_FIRST, 16'd1}, 1'b1,
          '{ST_OK, 21'd0, 21'd1024, 6'd1, 6'd1}},
        '{'{REQ_ALLOC, 21'd0, FIT_FIRST, 16'd2}, 1'b1,
          '{ST_NO_FIT, 21'd0, 21'd0, 6'd1, 6'd1}},
        '{'{REQ_ALLOC, 21'd10, FIT_BAD, 16'd2}, 1'b1,
          '{ST_NO_FIT, 21'd0, 21'd0, 6'd1, 6'd1}},
        '{'{REQ_RELEASE, 21'd0, FIT_FIRST, 16'hFFFF}, 1'b1,
          '{ST_NO_ID, 21'd0, 21'd0, 6'd1, 6'd1}},
        '{'{REQ_ALLOC, 21'(MEM_BYTES), FIT_WORST, 16'd3}, 1'b1,
          '{ST_NO_FIT, 21'd0, 21'd0, 6'd1, 6'd1}},
        '{'{REQ_NONE, 21'h1FFFFF, FIT_BAD, 16'hFFFF}, 1'b1,
          '{ST_OK, 21'd0, 21'd0, 6'd1, 6'd1}},
        '{'{REQ_COMPACT, 21'd0, FIT_FIRST, 16'd0}, 1'b1,
          '{ST_OK, 21'd0, 21'd1024, 6'd1, 6'd1}},
        // take the whole remainder: the hole vanishes
        '{'{REQ_ALLOC, 21'd1047552, FIT_BEST, 16'hFFFF}, 1'b1,
          '{ST_OK, 21'd1024, 21'(MEM_BYTES), 6'd0, 6'd2}},
        '{'{REQ_ALLOC, 21'd1, FIT_FIRST, 16'd4}, 1'b1,
          '{ST_NO_FIT, 21'd0, 21'd0, 6'd0, 6'd2}},
        // memory full: compact leaves an empty hole at the top
        '{'{REQ_COMPACT, 21'd0, FIT_FIRST, 16'd0}, 1'b1,
          '{ST_OK, 21'd0, 21'(MEM_BYTES), 6'd1, 6'd2}},
        '{'{REQ_RELEASE, 21'd0, FIT_FIRST, 16'd1}, 1'b1,
          '{ST_OK, 21'd0, 21'd1024, 6'd2, 6'd1}},
        '{'{REQ_RELEASE, 21'd0, FIT_FIRST, 16'hFFFF}, 1'b1,
          '{ST_OK, 21'd1024, 21'(MEM_BYTES), 6'd3, 6'd0}},
        '{'{REQ_COMPACT, 21'd0, FIT_FIRST, 16'd0}, 1'b1,
          '{ST_OK, 21'd0, 21'd0, 6'd1, 6'd0}},
        // equal holes for the fit ties, then each strategy
        '{'{REQ_ALLOC, 21'd100, FIT_FIRST, 16'd10}, 1'b0, '{default: '0}},
        '{'{REQ_ALLOC, 21'd50, FIT_FIRST, 16'd11}, 1'b0, '{default: '0}},
        '{'{REQ_ALLOC, 21'd100, FIT_FIRST, 16'd12}, 1'b0, '{default: '0}},
        '{'{REQ_ALLOC, 21'd50, FIT_FIRST, 16'd13}, 1'b0, '{default: '0}},
        '{'{REQ_ALLOC, 21'd100, FIT_FIRST, 16'd14}, 1'b0, '{default: '0}},
        '{'{REQ_RELEASE, 21'd0, FIT_FIRST, 16'd10}, 1'b0, '{default: '0}},
        '{'{REQ_RELEASE, 21'd0, FIT_FIRST, 16'd12}, 1'b0, '{default: '0}},
        '{'{REQ_ALLOC, 21'd60, FIT_BEST, 16'd20}, 1'b0, '{default: '0}},
        '{'{REQ_ALLOC, 21'd40, FIT_BEST, 16'd21}, 1'b0, '{default: '0}},
        '{'{REQ_ALLOC, 21'd30, FIT_WORST, 16'd22}, 1'b0, '{default: '0}},
        '{'{REQ_ALLOC, 21'd40, FIT_FIRST, 16'h5AA5}, 1'b0, '{default: '0}}
    };

    initial
    begin
        request_t r;
        gap_lo[0] = 0;
        gap_hi[0] = MEM_BYTES;
        gap_n = 1;
        blk_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
            issue(plan[i].req, plan[i].typed, plan[i].want);

        // let the tables drain before filling them to the brim
        wait (pending_q.size() == 0);
        issue('{REQ_COMPACT, 21'd0, FIT_FIRST, 16'd0});
        while (blk_n > 0)
            issue('{REQ_RELEASE, 21'd0, FIT_FIRST, 16'(blk_owner[0])});
        issue('{REQ_COMPACT, 21'd0, FIT_FIRST, 16'd0});
        // one more than the segment table holds, then free them all:
        // unmerged holes run out before the last release
        for (int i = 0; i <= SEG_ENTRIES; i++)
            issue('{REQ_ALLOC, 21'd16, 2'(i % 3), 16'(100 + i)});
        for (int i = 0; i < SEG_ENTRIES; i++)
            issue('{REQ_RELEASE, 21'd0, FIT_FIRST, 16'(100 + i)});
        issue('{REQ_COMPACT, 21'd0, FIT_FIRST, 16'd0});

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            calm = (i >= 600 && i < 900);
            r = random_request();
            // mostly releases of owners that are present
            if (r.kind == REQ_RELEASE && blk_n > 0 && $urandom_range(99) < 70)
                r.owner = 16'(blk_owner[$urandom_range(blk_n - 1)]);
            issue(r);
        end
        calm = 1'b0;

        wait (pending_q.size() == 0);
        repeat (200) @(posedge clk);
        $display("%0d requests sent (%0d alloc, %0d release, %0d compact, %0d unknown)",
                 sent, kind_seen[REQ_ALLOC], kind_seen[REQ_RELEASE],
                 kind_seen[REQ_COMPACT], kind_seen[REQ_NONE]);
        $display("%0d results: %0d ok, %0d no fit, %0d no id, %0d full; %0d mismatches",
                 results_seen, code_seen[ST_OK], code_seen[ST_NO_FIT],
                 code_seen[ST_NO_ID], code_seen[ST_FULL], errors);
        if (errors == 0 && pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
